@@ design/spoac_pkg.sv @@
package spoac_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCALED_W = 14;
   localparam int CFG_W    = 13;
   localparam int SUM_W    = 17;
   localparam int OFFS_W   = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CFG_W-1:0] G_LEVEL_RESET = 13'd4096;
   localparam logic [CFG_W-1:0] WINDOW_RESET  = 13'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_G_LEVEL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 8'd1;

   typedef enum logic [2:0] {
      POS_FRONT = 3'd0,
      POS_BACK  = 3'd1,
      POS_UP    = 3'd2,
      POS_DOWN  = 3'd3,
      POS_RIGHT = 3'd4,
      POS_LEFT  = 3'd5
   } pos_type;

   typedef struct packed {
      pos_type pos;
      logic    load;
      logic    advance;
      logic    finish;
   } dp_cmd_type;

   typedef struct packed {
      logic qualify;
   } dp_sts_type;

endpackage

@@ design/spoac_ctrl.sv @@
module spoac_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output spoac_pkg::dp_cmd_type cmd,
   input  spoac_pkg::dp_sts_type sts
);
   import spoac_pkg::*;

   pos_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= POS_FRONT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // take an item whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.pos      = state_ff;
      cmd.load     = load;
      cmd.advance  = load && sts.qualify;
      cmd.finish   = load && sts.qualify && (state_ff == POS_LEFT);

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.advance) begin
         case (state_ff)
            POS_FRONT: state_in = POS_BACK;
            POS_BACK:  state_in = POS_UP;
            POS_UP:    state_in = POS_DOWN;
            POS_DOWN:  state_in = POS_RIGHT;
            POS_RIGHT: state_in = POS_LEFT;
            POS_LEFT:  state_in = POS_FRONT;
            default:   state_in = POS_FRONT;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_finish_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == POS_FRONT)
      else $error("orientation did not restart after the last position");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !sts.qualify) |=> state_ff == $past(state_ff))
      else $error("rejected item moved the orientation");
`endif

endmodule

@@ design/spoac_dp.sv @@
module spoac_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [spoac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [spoac_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [spoac_pkg::SAMPLE_W-1:0]  x_sample,
   input  logic signed [spoac_pkg::SAMPLE_W-1:0]  y_sample,
   input  logic signed [spoac_pkg::SAMPLE_W-1:0]  z_sample,
   input  spoac_pkg::dp_cmd_type                  cmd,
   output spoac_pkg::dp_sts_type                  sts,
   output logic                                   accepted,
   output logic [2:0]                             position,
   output logic                                   done_res,
   output logic signed [spoac_pkg::OFFS_W-1:0]    x_offset,
   output logic signed [spoac_pkg::OFFS_W-1:0]    y_offset,
   output logic signed [spoac_pkg::OFFS_W-1:0]    z_offset
);
   import spoac_pkg::*;

   localparam int CMP_W = SCALED_W + 1;
   localparam int NEG_W = SUM_W + 1;

   logic [CFG_W-1:0] g_ff, w_ff;
   logic signed [SUM_W-1:0] x_sum_ff, y_sum_ff, z_sum_ff;
   logic signed [SUM_W-1:0] x_sum_in, y_sum_in, z_sum_in;
   logic signed [SUM_W-1:0] x_fin_ff, y_fin_ff, z_fin_ff;
   logic signed [SUM_W-1:0] x_fin_in, y_fin_in, z_fin_in;
   logic       accepted_ff;
   logic [2:0] pos_ff;
   logic       done_ff;

   logic signed [CMP_W-1:0] xs, ys, zs, g_p, g_n, w_p, w_n;
   logic x_band, y_band, z_band;
   logic add_x, add_y, add_z;
   logic signed [SUM_W-1:0] x_add, y_add, z_add;

   // divide by 4 toward zero: bias negatives by 3 before the shift
   function automatic logic signed [CMP_W-1:0] scale(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W:0] adj;
      adj = {s[SAMPLE_W-1], s} + ((s[SAMPLE_W-1]) ? 17'sd3 : 17'sd0);
      return CMP_W'(adj >>> 2);
   endfunction

   // negate, then divide by 32 toward zero, keep the low byte
   function automatic logic [OFFS_W-1:0] offs(input logic signed [SUM_W-1:0] s);
      logic signed [NEG_W-1:0] n;
      logic signed [NEG_W-1:0] adj;
      n   = -NEG_W'(s);
      adj = n + ((n[NEG_W-1]) ? NEG_W'(31) : NEG_W'(0));
      return OFFS_W'(adj >>> 5);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= G_LEVEL_RESET;
         w_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_G_LEVEL) begin
            g_ff <= csr_wdata[CFG_W-1:0];
         end else if (csr_index == CSR_WINDOW) begin
            w_ff <= csr_wdata[CFG_W-1:0];
         end
      end
   end

   assign xs  = scale(x_sample);
   assign ys  = scale(y_sample);
   assign zs  = scale(z_sample);
   assign g_p = CMP_W'({2'b00, g_ff});
   assign g_n = -g_p;
   assign w_p = CMP_W'({2'b00, w_ff});
   assign w_n = -w_p;

   assign x_band = (xs > w_n) && (xs < w_p);
   assign y_band = (ys > w_n) && (ys < w_p);
   assign z_band = (zs > w_n) && (zs < w_p);

   always_comb begin
      sts.qualify = 1'b0;
      add_x = 1'b0;
      add_y = 1'b0;
      add_z = 1'b0;
      case (cmd.pos)
         POS_FRONT: begin
            sts.qualify = (zs > g_p) && x_band && y_band;
            add_x = 1'b1;
            add_y = 1'b1;
         end
         POS_BACK: begin
            sts.qualify = (zs < g_n) && x_band && y_band;
            add_x = 1'b1;
            add_y = 1'b1;
         end
         POS_UP: begin
            sts.qualify = (ys < g_n) && x_band && z_band;
            add_x = 1'b1;
            add_z = 1'b1;
         end
         POS_DOWN: begin
            sts.qualify = (ys > g_p) && x_band && z_band;
            add_x = 1'b1;
            add_z = 1'b1;
         end
         POS_RIGHT: begin
            sts.qualify = (xs > g_p) && y_band && z_band;
            add_y = 1'b1;
            add_z = 1'b1;
         end
         POS_LEFT: begin
            sts.qualify = (xs < g_n) && y_band && z_band;
            add_y = 1'b1;
            add_z = 1'b1;
         end
         default: begin
            sts.qualify = 1'b0;
         end
      endcase
   end

   assign x_add = x_sum_ff + (add_x ? SUM_W'(xs) : '0);
   assign y_add = y_sum_ff + (add_y ? SUM_W'(ys) : '0);
   assign z_add = z_sum_ff + (add_z ? SUM_W'(zs) : '0);

   always_comb begin
      x_sum_in = x_sum_ff;
      y_sum_in = y_sum_ff;
      z_sum_in = z_sum_ff;
      x_fin_in = x_fin_ff;
      y_fin_in = y_fin_ff;
      z_fin_in = z_fin_ff;
      if (cmd.finish) begin
         x_sum_in = '0;
         y_sum_in = '0;
         z_sum_in = '0;
      end else if (cmd.advance) begin
         x_sum_in = x_add;
         y_sum_in = y_add;
         z_sum_in = z_add;
      end
      // a zero sum gives a zero offset byte on items that do not finish
      if (cmd.load) begin
         x_fin_in = cmd.finish ? x_add : '0;
         y_fin_in = cmd.finish ? y_add : '0;
         z_fin_in = cmd.finish ? z_add : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_sum_ff <= '0;
         y_sum_ff <= '0;
         z_sum_ff <= '0;
      end else begin
         x_sum_ff <= x_sum_in;
         y_sum_ff <= y_sum_in;
         z_sum_ff <= z_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      x_fin_ff <= x_fin_in;
      y_fin_ff <= y_fin_in;
      z_fin_ff <= z_fin_in;
      if (cmd.load) begin
         accepted_ff <= sts.qualify;
         pos_ff      <= cmd.pos;
         done_ff     <= cmd.finish;
      end
   end

   assign accepted = accepted_ff;
   assign position = pos_ff;
   assign done_res = done_ff;
   assign x_offset = offs(x_fin_ff);
   assign y_offset = offs(y_fin_ff);
   assign z_offset = offs(z_fin_ff);

endmodule

@@ design/six_position_accel_offset_calibrator.sv @@
// Six-position accelerometer offset calibrator.
//
// req_ channel: one raw X/Y/Z sample per item (14-bit readings left-justified
// in 16 bits). rsp_ channel: one result per item telling whether the sample
// qualified for the expected orientation (front, back, up, down, right, left),
// the orientation it was tested against, and on the item that completes the
// left orientation the three offset register bytes.
// csr_ channel: register writes, index 0 one-g threshold, index 1 window;
// always ready, to be used only while no item is in flight.
//
// rsp_tvalid rises in the cycle after req acceptance; throughput is one item
// per cycle while rsp_tready is high, set by the compare and sum update in the
// datapath. The result register is the only buffer: while rsp_tvalid is high
// and rsp_tready is low, the result holds and req_tready drops.
//
// Reset (synchronous): orientation returns to front, the sums clear,
// the one-g threshold returns to 4096 and window to 1000.
module six_position_accel_offset_calibrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] x_sample, [31:16] y_sample, [47:32] z_sample
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] accepted, [3:1] position, [4] done_res, [12:5] x_offset,
   // [20:13] y_offset, [28:21] z_offset, [31:29] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [spoac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spoac_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spoac_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       accepted;
   logic [2:0] position;
   logic       done_res;
   logic signed [OFFS_W-1:0] x_offset, y_offset, z_offset;

   assign csr_ready = 1'b1;

   spoac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   spoac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .x_sample  (req_tdata[15:0]),
      .y_sample  (req_tdata[31:16]),
      .z_sample  (req_tdata[47:32]),
      .cmd       (cmd),
      .sts       (sts),
      .accepted  (accepted),
      .position  (position),
      .done_res  (done_res),
      .x_offset  (x_offset),
      .y_offset  (y_offset),
      .z_offset  (z_offset)
   );

   assign rsp_tdata = {3'b000, z_offset, y_offset, x_offset, done_res, position, accepted};

`ifndef SYNTHESIS
   a_done_on_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && done_res) |-> (accepted && position == POS_LEFT))
      else $error("done flagged outside a qualified left-orientation item");

   a_offsets_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !done_res) |-> (x_offset == '0 && y_offset == '0 && z_offset == '0))
      else $error("offset bytes nonzero on an item that did not finish");
`endif

endmodule
